[src/traffic_ca_velocity_update_core_assert.svh]
// ---------------------------------------------------------------------------
// traffic_ca_velocity_update_core_assert
// Assertion macros shared by the velocity update RTL.
// Each macro takes a label, the clock, the synchronous reset, an antecedent and a consequent.
// ---------------------------------------------------------------------------
`ifndef TRAFFIC_CA_VELOCITY_UPDATE_CORE_ASSERT_SVH
`define TRAFFIC_CA_VELOCITY_UPDATE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCVU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcvu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCVU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcvu: next-cycle check failed");

`endif

[src/tcvu_pkg.sv]
// ---------------------------------------------------------------------------
// tcvu_pkg
// Shared types and constants of the traffic velocity update core: register
// indexes and reset values, the reciprocal table used by the series unit and
// the stage control bundle passed to it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcvu_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_STEP       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_PROB_BASE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_PROB_SLOPE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_PROB        = 3'd4;

   // Register reset values.
   localparam logic [3:0]  MAX_SPEED_RESET        = 4'd5;
   localparam logic [3:0]  BRAKE_STEP_RESET       = 4'd2;
   localparam logic [15:0] ACCEL_PROB_BASE_RESET  = 16'd52429;
   localparam logic [15:0] ACCEL_PROB_SLOPE_RESET = 16'd4369;
   localparam logic [15:0] SLOW_PROB_RESET        = 16'd655;

   // Probability of one in Q0.16.
   localparam logic [15:0] PROB_ONE = 16'hFFFF;

   // Division by the braking step is a multiply by a rounded-up reciprocal.
   // With an 11-bit shift the quotient is exact for dividends below 128 and
   // divisors below 16. Entry zero is never used and holds the entry for one.
   localparam int RECIP_SHIFT = 11;
   localparam int RECIP_W     = 12;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
      12'd2048, 12'd2048, 12'd1024, 12'd683, 12'd512, 12'd410, 12'd342, 12'd293,
      12'd256,  12'd228,  12'd205,  12'd187, 12'd171, 12'd158, 12'd147, 12'd137
   };

   // Load enables of the stages held inside the series unit, and the valid
   // flag of its quotient stage.
   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
      logic en5;
      logic v3;
   } stage_ctrl_type;

endpackage

`default_nettype wire

[src/tcvu_if.sv]
// ---------------------------------------------------------------------------
// tcvu_if
// Valid/ready channels of the velocity update core: the request channel
// carries one vehicle, the response channel carries its next speed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcvu_req_if #(
   parameter int SPEED_LIMIT = 15,
   parameter int GAP_LIMIT   = 1023
);
   localparam int SPEED_W = $clog2(SPEED_LIMIT + 1);
   localparam int GAP_W   = $clog2(GAP_LIMIT + 1);

   logic               valid;
   logic               ready;
   logic [GAP_W-1:0]   gap_cells;
   logic [SPEED_W-1:0] own_speed;
   logic [SPEED_W-1:0] leader_speed;
   logic [15:0]        random_draw;
   logic               is_autonomous;
   logic               light_ahead;

   modport source (
      output valid, gap_cells, own_speed, leader_speed, random_draw,
             is_autonomous, light_ahead,
      input  ready
   );
   modport sink (
      input  valid, gap_cells, own_speed, leader_speed, random_draw,
             is_autonomous, light_ahead,
      output ready
   );
endinterface

interface tcvu_rsp_if #(
   parameter int SPEED_LIMIT = 15
);
   localparam int SPEED_W = $clog2(SPEED_LIMIT + 1);

   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] new_speed;

   modport source (
      output valid, new_speed,
      input  ready
   );
   modport sink (
      input  valid, new_speed,
      output ready
   );
endinterface

`default_nettype wire

[src/tcvu_series.sv]
// ---------------------------------------------------------------------------
// tcvu_series
// Four-stage pipeline for the braking series S(x) = sum of (x - i*m) over
// i = 0 .. floor(x/m), with S(x) = 0 for negative x, in closed form.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "traffic_ca_velocity_update_core_assert.svh"

module tcvu_series #(
   parameter int X_W = 5,
   parameter int D_W = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire tcvu_pkg::stage_ctrl_type ctrl,
   input  wire logic signed [D_W-1:0]   x_value,
   input  wire logic [3:0]              step_s1,
   input  wire logic [3:0]              step_s4,
   output logic [2*X_W:0]               series_sum
);
   localparam int P_W   = 2 * X_W + 1;
   localparam int T_W   = 2 * X_W;
   localparam int Q_W   = X_W + tcvu_pkg::RECIP_W;
   localparam int M_W   = 2 * X_W + 5;

   logic [X_W-1:0]              x2_ff;
   logic [tcvu_pkg::RECIP_W-1:0] recip2_ff;
   logic [X_W-1:0]              x2_in;
   logic [X_W-1:0]              x3_ff;
   logic [X_W-1:0]              n3_ff;
   logic [Q_W-1:0]              quot_prod;
   logic [P_W-1:0]              p4_ff;
   logic [T_W-1:0]              t4_ff;
   logic [X_W:0]                n_plus;
   logic [P_W-1:0]              tri_prod;
   logic [P_W-1:0]              p4_in;
   logic [P_W-1:0]              s5_ff;
   logic [M_W-1:0]              s5_wide;

   // A negative argument gives the same sum as zero, so it is clamped here.
   assign x2_in = x_value[D_W-1] ? '0 : x_value[X_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.en2) begin
         x2_ff     <= x2_in;
         recip2_ff <= tcvu_pkg::RECIP_TABLE[step_s1];
      end
   end

   // Quotient floor(x/m) by reciprocal multiply.
   assign quot_prod = Q_W'(x2_ff) * Q_W'(recip2_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en3) begin
         x3_ff <= x2_ff;
         n3_ff <= quot_prod[tcvu_pkg::RECIP_SHIFT +: X_W];
      end
   end

   // (n + 1) * x and the triangular number n * (n + 1) / 2.
   assign n_plus   = (X_W + 1)'(n3_ff) + (X_W + 1)'(1);
   assign p4_in    = P_W'(n_plus) * P_W'(x3_ff);
   assign tri_prod = P_W'(n3_ff) * P_W'(n_plus);

   always_ff @(posedge clock) begin
      if (ctrl.en4) begin
         p4_ff <= p4_in;
         t4_ff <= tri_prod[P_W-1:1];
      end
   end

   // Subtract m times the triangular number; the result is never negative.
   assign s5_wide = M_W'(p4_ff) - M_W'(step_s4) * M_W'(t4_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en5) begin
         s5_ff <= s5_wide[P_W-1:0];
      end
   end

   assign series_sum = s5_ff;

   // The quotient can never exceed the dividend, since the step is at least one.
   `TCVU_ASSERT_SAME(a_quot_bound, clock, reset, ctrl.v3, n3_ff <= x3_ff)

endmodule

`default_nettype wire

[src/traffic_ca_velocity_update_core.sv]
// ---------------------------------------------------------------------------
// traffic_ca_velocity_update_core
// Next-speed rule of a cellular traffic automaton for one vehicle per cycle.
//
// Usage: a vehicle (gap, own speed, leader speed, random draw, autonomous and
// light flags) is offered on req_if; a transfer takes place when valid and
// ready are both high. The next speed appears on rsp_if behind seven register
// stages: capture, reciprocal lookup, quotient, series products, series sum,
// threshold compare, and the output register. A new vehicle can be accepted
// in every cycle while the receiver keeps rsp_if.ready high, so the sustained
// rate is one item per cycle; the products of the series unit set the depth.
// When the receiver holds ready low the output register keeps its result,
// the stages behind it fill up one by one, and req_if.ready falls only when
// every stage holds an item; nothing is dropped or repeated.
// Configuration registers are written via csr_we/csr_index/csr_wdata, by the
// user only while no item is in flight; the block does not enforce it. Reset
// empties the pipeline and loads the register defaults, with no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "traffic_ca_velocity_update_core_assert.svh"

module traffic_ca_velocity_update_core #(
   parameter int SPEED_LIMIT = 15,
   parameter int GAP_LIMIT   = 1023
) (
   input  wire                                   clock,
   input  wire                                   reset,
   tcvu_req_if.sink                              req_if,
   tcvu_rsp_if.source                            rsp_if,
   input  wire                                   csr_we,
   input  wire logic [tcvu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tcvu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int SPEED_W = $clog2(SPEED_LIMIT + 1);
   localparam int GAP_W   = $clog2(GAP_LIMIT + 1);
   localparam int X_W     = SPEED_W + 1;
   localparam int D_W     = ((SPEED_W > 4) ? SPEED_W : 4) + 2;
   localparam int SUM_W   = 2 * X_W + 1;
   localparam int CMP_W   = ((GAP_W > SUM_W) ? GAP_W : SUM_W) + 1;
   localparam int PROD_W  = SPEED_W + 16;
   localparam int R_W     = ((X_W > 4) ? X_W : 4) + 1;
   localparam int N_ST    = 7;

   typedef struct packed {
      logic [GAP_W-1:0]   gap;
      logic [SPEED_W-1:0] vn;
      logic [SPEED_W-1:0] vp;
      logic [15:0]        draw;
      logic               is_auto;
      logic               light;
      logic [3:0]         m;
      logic [PROD_W-1:0]  prod;
      logic [15:0]        ra;
      logic               le_ra;
      logic               le_slow;
      logic               ge_acc;
      logic               ge_keep;
      logic               ge_dec;
      logic               ge_stop;
   } item_type;

   // Configuration registers.
   logic [3:0]  max_speed_ff;
   logic [3:0]  brake_step_ff;
   logic [15:0] accel_prob_base_ff;
   logic [15:0] accel_prob_slope_ff;
   logic [15:0] slow_prob_ff;

   // Pipeline state.
   logic [N_ST:1]      valid_ff;
   logic [N_ST:1]      stage_ready;
   item_type           st_ff [1:6];
   item_type           st_in [1:6];
   logic [SPEED_W-1:0] new_speed_ff;
   logic [SPEED_W-1:0] new_speed_in;

   tcvu_pkg::stage_ctrl_type series_ctrl;

   logic signed [D_W-1:0] vn_s;
   logic signed [D_W-1:0] vp_s;
   logic signed [D_W-1:0] m_s;
   logic signed [D_W-1:0] x_acc;
   logic signed [D_W-1:0] x_keep;
   logic signed [D_W-1:0] x_dec;
   logic signed [D_W-1:0] x_stop;
   logic signed [D_W-1:0] x_lead;
   logic [SUM_W-1:0]      s_acc;
   logic [SUM_W-1:0]      s_keep;
   logic [SUM_W-1:0]      s_dec;
   logic [SUM_W-1:0]      s_stop;
   logic [SUM_W-1:0]      s_lead;
   logic [CMP_W-1:0]      gap_plus_lead;
   logic [PROD_W:0]       ra_sum;
   logic [R_W-1:0]        res;
   logic [R_W-1:0]        vn_e;
   logic [R_W-1:0]        m_e;
   logic [R_W-1:0]        vmax_e;
   logic [R_W-1:0]        inc_e;
   logic [R_W-1:0]        dec1_e;
   logic [R_W-1:0]        decm_e;
   logic [3:0]            step_eff;
   logic [GAP_W-1:0]      gap_sat;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff        <= tcvu_pkg::MAX_SPEED_RESET;
         brake_step_ff       <= tcvu_pkg::BRAKE_STEP_RESET;
         accel_prob_base_ff  <= tcvu_pkg::ACCEL_PROB_BASE_RESET;
         accel_prob_slope_ff <= tcvu_pkg::ACCEL_PROB_SLOPE_RESET;
         slow_prob_ff        <= tcvu_pkg::SLOW_PROB_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tcvu_pkg::CSR_MAX_SPEED:        max_speed_ff        <= csr_wdata[3:0];
            tcvu_pkg::CSR_BRAKE_STEP:       brake_step_ff       <= csr_wdata[3:0];
            tcvu_pkg::CSR_ACCEL_PROB_BASE:  accel_prob_base_ff  <= csr_wdata;
            tcvu_pkg::CSR_ACCEL_PROB_SLOPE: accel_prob_slope_ff <= csr_wdata;
            tcvu_pkg::CSR_SLOW_PROB:        slow_prob_ff        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Ready chain: a stage can load when it is empty or the next one moves on.
   always_comb begin
      stage_ready[N_ST] = !valid_ff[N_ST] || rsp_if.ready;
      for (int k = N_ST - 1; k >= 1; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k + 1];
      end
   end

   assign req_if.ready = stage_ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[1]) begin
            valid_ff[1] <= req_if.valid;
         end
         for (int k = 2; k <= N_ST; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   // Capture: saturate the gap, zero the leader at a light, fix a zero step.
   assign gap_sat  = (req_if.gap_cells > GAP_W'(GAP_LIMIT)) ? GAP_W'(GAP_LIMIT)
                                                             : req_if.gap_cells;
   assign step_eff = (brake_step_ff == 4'd0) ? 4'd1 : brake_step_ff;

   // Series arguments, taken from the capture stage.
   assign vn_s   = $signed(D_W'(st_ff[1].vn));
   assign vp_s   = $signed(D_W'(st_ff[1].vp));
   assign m_s    = $signed(D_W'(st_ff[1].m));
   assign x_acc  = vn_s + D_W'(1);
   assign x_keep = vn_s;
   assign x_dec  = vn_s - D_W'(1);
   assign x_stop = vn_s - m_s;
   assign x_lead = vp_s - m_s;

   // Acceleration probability sum before its cap.
   assign ra_sum = (PROD_W + 1)'(accel_prob_base_ff) + (PROD_W + 1)'(st_ff[2].prod);

   // The gap meets a threshold S - dp (clamped at zero) exactly when gap + dp >= S.
   assign gap_plus_lead = CMP_W'(st_ff[5].gap) + CMP_W'(s_lead);

   // Next value of each stage.
   always_comb begin
      st_in[1]         = '0;
      st_in[1].gap     = gap_sat;
      st_in[1].vn      = req_if.own_speed;
      st_in[1].vp      = req_if.light_ahead ? '0 : req_if.leader_speed;
      st_in[1].draw    = req_if.random_draw;
      st_in[1].is_auto = req_if.is_autonomous;
      st_in[1].light   = req_if.light_ahead;
      st_in[1].m       = step_eff;

      st_in[2]         = st_ff[1];
      st_in[2].prod    = PROD_W'(st_ff[1].vn) * PROD_W'(accel_prob_slope_ff);
      st_in[2].le_slow = st_ff[1].draw <= slow_prob_ff;

      st_in[3]         = st_ff[2];
      st_in[3].ra      = (ra_sum > (PROD_W + 1)'(tcvu_pkg::PROB_ONE)) ? tcvu_pkg::PROB_ONE
                                                                    : ra_sum[15:0];

      st_in[4]         = st_ff[3];
      st_in[4].le_ra   = st_ff[3].draw <= st_ff[3].ra;

      st_in[5]         = st_ff[4];

      st_in[6]         = st_ff[5];
      st_in[6].ge_acc  = gap_plus_lead >= CMP_W'(s_acc);
      st_in[6].ge_keep = gap_plus_lead >= CMP_W'(s_keep);
      st_in[6].ge_dec  = gap_plus_lead >= CMP_W'(s_dec);
      st_in[6].ge_stop = CMP_W'(st_ff[5].gap) >= CMP_W'(s_stop);
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= 6; k++) begin
         if (stage_ready[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // Series units for the four thresholds and the leader's stopping distance.
   assign series_ctrl.en2 = stage_ready[2];
   assign series_ctrl.en3 = stage_ready[3];
   assign series_ctrl.en4 = stage_ready[4];
   assign series_ctrl.en5 = stage_ready[5];
   assign series_ctrl.v3  = valid_ff[3];

   tcvu_series #(.X_W(X_W), .D_W(D_W)) u_series_acc (
      .clock(clock), .reset(reset), .ctrl(series_ctrl), .x_value(x_acc),
      .step_s1(st_ff[1].m), .step_s4(st_ff[4].m), .series_sum(s_acc)
   );
   tcvu_series #(.X_W(X_W), .D_W(D_W)) u_series_keep (
      .clock(clock), .reset(reset), .ctrl(series_ctrl), .x_value(x_keep),
      .step_s1(st_ff[1].m), .step_s4(st_ff[4].m), .series_sum(s_keep)
   );
   tcvu_series #(.X_W(X_W), .D_W(D_W)) u_series_dec (
      .clock(clock), .reset(reset), .ctrl(series_ctrl), .x_value(x_dec),
      .step_s1(st_ff[1].m), .step_s4(st_ff[4].m), .series_sum(s_dec)
   );
   tcvu_series #(.X_W(X_W), .D_W(D_W)) u_series_stop (
      .clock(clock), .reset(reset), .ctrl(series_ctrl), .x_value(x_stop),
      .step_s1(st_ff[1].m), .step_s4(st_ff[4].m), .series_sum(s_stop)
   );
   tcvu_series #(.X_W(X_W), .D_W(D_W)) u_series_lead (
      .clock(clock), .reset(reset), .ctrl(series_ctrl), .x_value(x_lead),
      .step_s1(st_ff[1].m), .step_s4(st_ff[4].m), .series_sum(s_lead)
   );

   // Speed decision from the threshold flags.
   assign vn_e   = R_W'(st_ff[6].vn);
   assign m_e    = R_W'(st_ff[6].m);
   assign vmax_e = R_W'(max_speed_ff);
   assign inc_e  = vn_e + R_W'(1);
   assign dec1_e = (vn_e == '0) ? '0 : vn_e - R_W'(1);
   assign decm_e = (vn_e > m_e) ? vn_e - m_e : '0;

   always_comb begin
      res = '0;
      if (st_ff[6].ge_acc) begin
         if (st_ff[6].is_auto || st_ff[6].le_ra) begin
            res = (inc_e < vmax_e) ? inc_e : vmax_e;
         end else begin
            res = vn_e;
         end
      end else if (st_ff[6].ge_keep) begin
         res = (!st_ff[6].is_auto && st_ff[6].le_slow) ? dec1_e : vn_e;
      end else if (st_ff[6].ge_dec && vn_e != '0) begin
         res = dec1_e;
      end else if (!st_ff[6].ge_dec && vn_e != '0
                   && (!st_ff[6].light || st_ff[6].ge_stop)) begin
         res = decm_e;
      end else if (st_ff[6].light && !st_ff[6].ge_stop) begin
         res = vn_e;
      end
      // Clamp to the configured maximum and to the speed range.
      if (res > vmax_e) begin
         res = vmax_e;
      end
      if (res > R_W'(SPEED_LIMIT)) begin
         res = R_W'(SPEED_LIMIT);
      end
      new_speed_in = res[SPEED_W-1:0];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (stage_ready[N_ST]) begin
         new_speed_ff <= new_speed_in;
      end
   end

   assign rsp_if.valid     = valid_ff[N_ST];
   assign rsp_if.new_speed = new_speed_ff;

   // Requests are refused only when every stage holds an item.
   `TCVU_ASSERT_SAME(a_full_when_blocked, clock, reset, !req_if.ready, &valid_ff)
   // A result only appears when the stage before it held one.
   `TCVU_ASSERT_SAME(a_out_from_prev, clock, reset, $rose(valid_ff[N_ST]), $past(valid_ff[6]))
   // A stalled middle stage keeps its item.
   `TCVU_ASSERT_NEXT(a_stall_keeps, clock, reset, valid_ff[3] && !stage_ready[3], valid_ff[3])

endmodule

`default_nettype wire

[tb/sv/traffic_ca_velocity_update_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// traffic_ca_velocity_update_checker
// Watches the request, response and register ports of the velocity update
// core. It keeps its own copy of the registers, predicts the next speed of
// every vehicle at its request transfer, and compares each response transfer
// with the oldest prediction. It reports the number of failures and the
// number of predictions still waiting.
// ---------------------------------------------------------------------------

module traffic_ca_velocity_update_checker (
   input  wire                                   clock,
   input  wire                                   reset,
   tcvu_req_if                                   req_mon,
   tcvu_rsp_if                                   rsp_mon,
   input  wire                                   csr_we,
   input  wire logic [tcvu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tcvu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                    error_count,
   output int                                    pending
);
   import tcvu_pkg::*;

   // Local copy of the configuration registers.
   logic [3:0]  max_speed_q;
   logic [3:0]  brake_step_q;
   logic [15:0] accel_base_q;
   logic [15:0] accel_slope_q;
   logic [15:0] slow_prob_q;

   // Next speeds predicted at request transfers, oldest first.
   logic [3:0] predicted_speeds [$];

   // Distance covered while braking from speed x down in steps of step.
   function automatic int braking_distance(input int x, input int step);
      int n;
      if (x < 0) return 0;
      n = x / step;
      return (n + 1) * x - step * ((n * (n + 1)) / 2);
   endfunction

   function automatic int floor_zero(input int x);
      return (x < 0) ? 0 : x;
   endfunction

   // Next speed of one vehicle under the current register values.
   function automatic logic [3:0] next_speed(
      input logic [9:0]  gap_in,
      input logic [3:0]  own_in,
      input logic [3:0]  lead_in,
      input logic [15:0] draw_in,
      input logic        autonomous,
      input logic        light
   );
      int          gap;
      int          vn;
      int          vp;
      int          m;
      int          vmax;
      int          lead_stop;
      int          acc_dist;
      int          keep_dist;
      int          dec_dist;
      int          stop_dist;
      int          speed;
      int unsigned draw;
      int unsigned accel_p;
      gap   = int'(gap_in);
      vn    = int'(own_in);
      vp    = light ? 0 : int'(lead_in);
      draw  = draw_in;
      m     = (brake_step_q == 4'd0) ? 1 : int'(brake_step_q);
      vmax  = int'(max_speed_q);
      speed = 0;

      // Safety distances; acc, keep and dec less what the leader still travels.
      lead_stop = braking_distance(vp - m, m);
      acc_dist  = floor_zero(braking_distance(vn + 1, m) - lead_stop);
      keep_dist = floor_zero(braking_distance(vn, m) - lead_stop);
      dec_dist  = floor_zero(braking_distance(vn - 1, m) - lead_stop);
      stop_dist = braking_distance(vn - m, m);

      // Speed-dependent acceleration probability, capped at one.
      accel_p = int'(accel_base_q) + vn * int'(accel_slope_q);
      if (accel_p > PROB_ONE) accel_p = PROB_ONE;

      if (gap >= acc_dist) begin
         if (autonomous || draw <= accel_p) speed = (vn + 1 < vmax) ? vn + 1 : vmax;
         else speed = vn;
      end else if (gap >= keep_dist) begin
         if (!autonomous && draw <= slow_prob_q) speed = floor_zero(vn - 1);
         else speed = vn;
      end else if (gap >= dec_dist && vn > 0) begin
         speed = floor_zero(vn - 1);
      end else if (gap < dec_dist && vn > 0 && (!light || gap >= stop_dist)) begin
         speed = floor_zero(vn - m);
      end else if (light && gap < stop_dist) begin
         // Too close to stop before the light, so the speed is held.
         speed = vn;
      end

      if (speed > vmax) speed = vmax;
      if (speed > 15) speed = 15;
      return 4'(speed);
   endfunction

   // Register writes, prediction at request transfers, comparison at
   // response transfers.
   always @(posedge clock) begin
      logic [3:0] wanted;
      if (reset) begin
         max_speed_q   <= MAX_SPEED_RESET;
         brake_step_q  <= BRAKE_STEP_RESET;
         accel_base_q  <= ACCEL_PROB_BASE_RESET;
         accel_slope_q <= ACCEL_PROB_SLOPE_RESET;
         slow_prob_q   <= SLOW_PROB_RESET;
         predicted_speeds.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_SPEED:        max_speed_q   <= csr_wdata[3:0];
               CSR_BRAKE_STEP:       brake_step_q  <= csr_wdata[3:0];
               CSR_ACCEL_PROB_BASE:  accel_base_q  <= csr_wdata;
               CSR_ACCEL_PROB_SLOPE: accel_slope_q <= csr_wdata;
               CSR_SLOW_PROB:        slow_prob_q   <= csr_wdata;
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            predicted_speeds.push_back(next_speed(req_mon.gap_cells, req_mon.own_speed,
                                                  req_mon.leader_speed, req_mon.random_draw,
                                                  req_mon.is_autonomous, req_mon.light_ahead));
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_speeds.size() == 0) begin
               $error("new_speed: unexpected transfer, expected none, actual %0d",
                      rsp_mon.new_speed);
               error_count <= error_count + 1;
            end else begin
               wanted = predicted_speeds.pop_front();
               if (rsp_mon.new_speed !== wanted) begin
                  $error("new_speed: expected %0d, actual %0d", wanted, rsp_mon.new_speed);
                  error_count <= error_count + 1;
               end
            end
         end

         pending <= predicted_speeds.size();
      end
   end

endmodule

[tb/sv/traffic_ca_velocity_update_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// traffic_ca_velocity_update_core_tb
// Drives the velocity update core with a short directed set of vehicles and
// then with random vehicles under several register settings, including the
// extremes. Both channels idle at random in two of three phases. The checker
// beside the core predicts and compares every response; this module gives the
// verdict.
// ---------------------------------------------------------------------------

module traffic_ca_velocity_update_core_tb;
   import tcvu_pkg::*;

   typedef struct packed {
      logic [9:0]  gap;
      logic [3:0]  own;
      logic [3:0]  lead;
      logic [15:0] draw;
      logic        autonomous;
      logic        light;
   } vehicle_t;

   typedef struct packed {
      logic [3:0]  max_speed;
      logic [3:0]  brake_step;
      logic [15:0] accel_base;
      logic [15:0] accel_slope;
      logic [15:0] slow_prob;
   } settings_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     pending;
   int                     send_idle_pct;
   int                     take_idle_pct;
   settings_t              active;

   tcvu_req_if req_chan ();
   tcvu_rsp_if rsp_chan ();

   traffic_ca_velocity_update_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   traffic_ca_velocity_update_checker speed_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   // Clock with a 12 ns period.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver stalls at random at the rate of the current phase.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   function automatic vehicle_t make_vehicle(input int gap, input int own, input int lead,
                                             input int draw, input bit autonomous,
                                             input bit light);
      vehicle_t v;
      v.gap        = 10'(gap);
      v.own        = 4'(own);
      v.lead       = 4'(lead);
      v.draw       = 16'(draw);
      v.autonomous = autonomous;
      v.light      = light;
      return v;
   endfunction

   // Random vehicle: mostly short gaps and speeds within the limit, with
   // draws clustered around the probability thresholds.
   function automatic vehicle_t random_vehicle(input settings_t cfg);
      vehicle_t v;
      int       pick;
      int       target;
      pick  = $urandom_range(99);
      v.gap = (pick < 75) ? 10'($urandom_range(140)) : 10'($urandom);
      v.own = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(cfg.max_speed));
      v.lead = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(cfg.max_speed));
      v.autonomous = 1'($urandom);
      v.light = ($urandom_range(3) == 0);
      pick = $urandom_range(99);
      if (pick < 35) begin
         v.draw = 16'($urandom);
      end else if (pick < 85) begin
         if (pick < 60) target = int'(cfg.slow_prob);
         else target = int'(cfg.accel_base) + int'(v.own) * int'(cfg.accel_slope);
         target = target + int'($urandom_range(4)) - 2;
         if (target < 0) target = 0;
         if (target > 65535) target = 65535;
         v.draw = 16'(target);
      end else begin
         v.draw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      return v;
   endfunction

   // One request transfer, preceded by random idle cycles.
   task automatic send_vehicle(input vehicle_t v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.gap_cells     <= v.gap;
      req_chan.own_speed     <= v.own;
      req_chan.leader_speed  <= v.lead;
      req_chan.random_draw   <= v.draw;
      req_chan.is_autonomous <= v.autonomous;
      req_chan.light_ahead   <= v.light;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Hold the requests until every predicted speed has been returned.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write all five registers; unused upper bits of the narrow ones are random.
   task automatic apply_settings(input settings_t s);
      logic [CSR_INDEX_W-1:0] regs   [5];
      logic [CSR_DATA_W-1:0]  values [5];
      regs   = '{CSR_MAX_SPEED, CSR_BRAKE_STEP, CSR_ACCEL_PROB_BASE,
                 CSR_ACCEL_PROB_SLOPE, CSR_SLOW_PROB};
      values = '{{12'($urandom), s.max_speed}, {12'($urandom), s.brake_step},
                 s.accel_base, s.accel_slope, s.slow_prob};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      active = s;
   endtask

   // Main stimulus.
   initial begin
      vehicle_t  probes [$];
      settings_t plan   [8];

      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.gap_cells     = '0;
      req_chan.own_speed     = '0;
      req_chan.leader_speed  = '0;
      req_chan.random_draw   = '0;
      req_chan.is_autonomous = 1'b0;
      req_chan.light_ahead   = 1'b0;
      send_idle_pct          = 22;
      take_idle_pct          = 78;
      active = '{MAX_SPEED_RESET, BRAKE_STEP_RESET, ACCEL_PROB_BASE_RESET,
                 ACCEL_PROB_SLOPE_RESET, SLOW_PROB_RESET};

      // Directed vehicles under the reset register values.
      probes.push_back(make_vehicle(0, 0, 0, 0, 0, 0));             // stopped, over-brake floor
      probes.push_back(make_vehicle(1023, 15, 15, 65535, 1, 1));    // above limit, at a light
      probes.push_back(make_vehicle(1023, 0, 0, 52429, 0, 0));      // draw on the accel threshold
      probes.push_back(make_vehicle(1023, 0, 0, 52430, 0, 0));      // draw just above it
      probes.push_back(make_vehicle(1023, 15, 0, 65535, 0, 0));     // capped accel probability
      probes.push_back(make_vehicle(6, 3, 0, 65535, 1, 0));         // gap on the accelerate bound
      probes.push_back(make_vehicle(5, 3, 0, 655, 0, 0));           // over-brake on its threshold
      probes.push_back(make_vehicle(5, 3, 0, 656, 0, 0));           // keep speed
      probes.push_back(make_vehicle(5, 3, 0, 0, 1, 0));             // autonomous never over-brakes
      probes.push_back(make_vehicle(3, 3, 0, 0, 0, 0));             // brake by one
      probes.push_back(make_vehicle(1, 3, 0, 0, 0, 0));             // emergency braking
      probes.push_back(make_vehicle(0, 1, 0, 0, 0, 0));             // slow car, brake by one
      probes.push_back(make_vehicle(0, 4, 15, 0, 0, 0));            // fast leader frees the gap
      probes.push_back(make_vehicle(0, 10, 7, 0, 0, 1));            // light too close to stop
      probes.push_back(make_vehicle(3, 4, 9, 0, 0, 1));             // light, emergency braking
      probes.push_back(make_vehicle(1, 4, 9, 0, 0, 1));             // light below stopping bound
      probes.push_back(make_vehicle(1023, 5, 5, 0, 0, 0));          // already at max speed
      probes.push_back(make_vehicle(512, 8, 3, 32768, 0, 1));
      probes.push_back(make_vehicle(0, 15, 0, 65535, 0, 0));        // hard braking from the top
      probes.push_back(make_vehicle(0, 0, 15, 65535, 0, 1));        // stopped at a light
      probes.push_back(make_vehicle(10'h2AA, 4'hA, 4'h5, 16'hAAAA, 1, 0));
      probes.push_back(make_vehicle(10'h155, 4'h5, 4'hA, 16'h5555, 0, 1));

      // Register settings, the extremes among them.
      plan[0] = '{4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      plan[1] = '{4'd0, 4'd0, 16'h0000, 16'h0000, 16'h0000};
      plan[2] = '{4'd15, 4'd1, 16'h0000, 16'h0000, 16'h0000};
      plan[3] = '{4'd1, 4'd1, 16'hFFFF, 16'h0000, 16'hFFFF};
      plan[4] = '{4'd7, 4'd3, 16'd30000, 16'd3000, 16'd20000};
      plan[5] = '{4'($urandom_range(1, 15)), 4'($urandom_range(15)), 16'($urandom),
                  16'($urandom), 16'($urandom)};
      plan[6] = '{4'd15, 4'd2, 16'd52429, 16'd4369, 16'd655};
      plan[7] = '{4'd9, 4'd4, 16'($urandom), 16'($urandom_range(8000)),
                  16'($urandom_range(30000))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) send_vehicle(probes[i]);

      for (int s = 0; s < 8; s++) begin
         // Sender idles less than the receiver, then the other way round, then neither.
         if (s < 3) begin
            send_idle_pct <= 22;
            take_idle_pct <= 78;
         end else if (s < 6) begin
            send_idle_pct <= 78;
            take_idle_pct <= 22;
         end else begin
            send_idle_pct <= 0;
            take_idle_pct <= 0;
         end
         drain();
         apply_settings(plan[s]);
         repeat (122) send_vehicle(random_vehicle(active));
      end

      drain();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/tcvu_pkg.sv
src/tcvu_if.sv
src/tcvu_series.sv
src/traffic_ca_velocity_update_core.sv
tb/sv/traffic_ca_velocity_update_checker.sv
tb/sv/traffic_ca_velocity_update_core_tb.sv
